### sv/mmrd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mmrd_pkg: shared types and constants of the meter response decoder
// Status codes, field kinds, the field map of both register layouts and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package mmrd_pkg;

  typedef enum logic [1:0] {
    STATUS_VALUE  = 2'd0,
    STATUS_CRC    = 2'd1,
    STATUS_FORMAT = 2'd2,
    STATUS_LENGTH = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    KIND_U16 = 3'd0,
    KIND_S16 = 3'd1,
    KIND_U32 = 3'd2,
    KIND_S32 = 3'd3,
    KIND_U64 = 3'd4
  } kind_e;

  localparam int unsigned IDX_W = 6;

  localparam logic [IDX_W-1:0] ELEC_FIRST   = 6'd0;
  localparam logic [IDX_W-1:0] ELEC_LAST    = 6'd28;
  localparam logic [IDX_W-1:0] ENERGY_FIRST = 6'd29;
  localparam logic [IDX_W-1:0] ENERGY_LAST  = 6'd33;

  localparam logic [7:0]  FUNC_READ_HOLDING = 8'h03;
  localparam logic [7:0]  BC_ELEC           = 8'h88;
  localparam logic [7:0]  BC_ENERGY         = 8'h70;
  localparam logic [15:0] CRC_INIT          = 16'hFFFF;
  localparam logic [15:0] CRC_POLY          = 16'hA001;

  // Address, function code, byte count and two CRC bytes.
  localparam int unsigned FRAME_OVERHEAD = 5;
  localparam int unsigned MIN_FRAME      = 5;

  // Byte offset of the first byte of a field within the frame.
  function automatic logic [7:0] field_offset(input logic [IDX_W-1:0] idx);
    logic [7:0] off;
    if (idx < 6'd12) begin
      off = 8'(3 + 4 * idx);
    end else if (idx < 6'd24) begin
      off = 8'(55 + 4 * (idx - 6'd12));
    end else if (idx == 6'd24) begin
      off = 8'd103;
    end else if (idx < ENERGY_FIRST) begin
      off = 8'(131 + 2 * (idx - 6'd25));
    end else if (idx < ENERGY_LAST) begin
      off = 8'(3 + 24 * (idx - ENERGY_FIRST));
    end else begin
      off = 8'd107;
    end
    return off;
  endfunction

  function automatic kind_e field_kind(input logic [IDX_W-1:0] idx);
    kind_e k;
    if (idx < 6'd12) begin
      k = KIND_U32;
    end else if (idx < 6'd24) begin
      k = KIND_S32;
    end else if (idx == 6'd24) begin
      k = KIND_U16;
    end else if (idx < ENERGY_FIRST) begin
      k = KIND_S16;
    end else begin
      k = KIND_U64;
    end
    return k;
  endfunction

  function automatic logic [3:0] field_bytes(input kind_e k);
    logic [3:0] n;
    unique case (k)
      KIND_U16, KIND_S16: n = 4'd2;
      KIND_U32, KIND_S32: n = 4'd4;
      default:            n = 4'd8;
    endcase
    return n;
  endfunction

  // Controller to datapath.
  typedef struct packed {
    logic             in_ready;
    logic             rd_en;
    logic             load_value;
    logic             load_status;
    logic             clear_frame;
    logic             last;
    logic [IDX_W-1:0] idx;
    logic [2:0]       byte_sel;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic    frame_end;
    logic    reject;
    status_e code;
    logic    elec;
    logic    out_taken;
  } stat_t;

endpackage
`default_nettype wire

### sv/mmrd_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mmrd_ctrl: frame sequencer
// Collects bytes until frame end; for a rejected frame hands the status on, else walks
// the field map, fetching each field byte by byte and handing it to the output register.
// ----------------------------------------------------------------------------
module mmrd_ctrl
  import mmrd_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire stat_t stat_i,
  output cmd_t       cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CHECK = 6'b000010,
    S_FETCH = 6'b000100,
    S_DRAIN = 6'b001000,
    S_LOAD  = 6'b010000,
    S_EMIT  = 6'b100000
  } state_e;

  state_e           state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [2:0]       sel_q, sel_d;
  logic             elec_q, elec_d;
  logic             last_q, last_d;

  logic [3:0]       nbytes;
  logic             is_last_idx;

  assign nbytes      = field_bytes(field_kind(idx_q));
  assign is_last_idx = (idx_q == (elec_q ? ELEC_LAST : ENERGY_LAST));

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    sel_d   = sel_q;
    elec_d  = elec_q;
    last_d  = last_q;
    cmd_o   = '0;
    cmd_o.idx      = idx_q;
    cmd_o.byte_sel = sel_q;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (stat_i.frame_end) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat_i.reject) begin
          cmd_o.load_status = 1'b1;
          last_d  = 1'b1;
          state_d = S_EMIT;
        end else begin
          elec_d  = stat_i.elec;
          idx_d   = stat_i.elec ? ELEC_FIRST : ENERGY_FIRST;
          sel_d   = '0;
          state_d = S_FETCH;
        end
      end
      S_FETCH: begin
        cmd_o.rd_en = 1'b1;
        if ({1'b0, sel_q} == nbytes - 4'd1) begin
          sel_d   = '0;
          state_d = S_DRAIN;
        end else begin
          sel_d = sel_q + 3'd1;
        end
      end
      S_DRAIN: begin
        state_d = S_LOAD;
      end
      S_LOAD: begin
        cmd_o.load_value = 1'b1;
        cmd_o.last       = is_last_idx;
        last_d  = is_last_idx;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (stat_i.out_taken) begin
          if (last_q) begin
            cmd_o.clear_frame = 1'b1;
            state_d = S_IDLE;
          end else begin
            idx_d   = idx_q + 6'd1;
            state_d = S_FETCH;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      sel_q   <= '0;
      elec_q  <= 1'b0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      sel_q   <= sel_d;
      elec_q  <= elec_d;
      last_q  <= last_d;
    end
  end

endmodule
`default_nettype wire

### sv/mmrd_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mmrd_datapath: frame store, CRC and field decoder
// Stores the frame, runs the CRC with a two-byte hold-back, checks length, CRC
// and header at frame end and assembles and decodes big-endian fields.
// ----------------------------------------------------------------------------
module mmrd_datapath
  import mmrd_pkg::*;
#(
  parameter int unsigned FRAME_BYTES = 256
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire cmd_t             cmd_i,
  output stat_t                 stat_o,
  input  wire logic             in_valid_i,
  input  wire logic [7:0]       in_byte_i,
  input  wire logic             in_end_i,
  input  wire logic             out_ready_i,
  output logic                  out_valid_o,
  output status_e               out_status_o,
  output logic [IDX_W-1:0]      out_idx_o,
  output logic [63:0]           out_value_o,
  output logic                  out_last_o
);

  localparam int unsigned AW = $clog2(FRAME_BYTES);
  localparam int unsigned CW = $clog2(FRAME_BYTES + 2);

  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [63:0] decode(input kind_e k, input logic [63:0] a);
    logic [63:0] v;
    unique case (k)
      KIND_U16: v = (a[15:0] == 16'hFFFF) ? 64'd0 : {48'd0, a[15:0]};
      KIND_S16: v = (a[15:0] == 16'h7FFF) ? 64'd0 : {{48{a[15]}}, a[15:0]};
      KIND_U32: v = (a[31:0] == 32'hFFFF_FFFF) ? 64'd0 : {32'd0, a[31:0]};
      KIND_S32: v = (a[31:0] == 32'h7FFF_FFFF) ? 64'd0 : {{32{a[31]}}, a[31:0]};
      default:  v = (a == '1) ? 64'd0 : a;
    endcase
    return v;
  endfunction

  logic [7:0]    mem [FRAME_BYTES];
  logic [7:0]    rdata_q;
  logic          take_q;
  logic [63:0]   acc_q;

  logic [CW-1:0] count_q;
  logic [15:0]   crc_q;
  logic [15:0]   dly_q;
  logic [7:0]    fn_q;
  logic [7:0]    bc_q;

  logic          in_fire;
  logic          room;
  logic [AW-1:0] raddr;
  logic [15:0]   crc_rx;
  logic          chk_reject;
  status_e       chk_code;

  logic             out_valid_q;
  status_e          out_status_q;
  logic [IDX_W-1:0] out_idx_q;
  logic [63:0]      out_value_q;
  logic             out_last_q;

  assign in_fire = in_valid_i & cmd_i.in_ready;
  assign room    = (count_q < CW'(FRAME_BYTES));
  assign raddr   = AW'(field_offset(cmd_i.idx)) + AW'(cmd_i.byte_sel);
  // Second-to-last byte is the low CRC byte, the last one the high byte.
  assign crc_rx  = {dly_q[7:0], dly_q[15:8]};

  // Frame store.
  always_ff @(posedge clk_i) begin
    if (in_fire && room) begin
      mem[count_q[AW-1:0]] <= in_byte_i;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_q) begin
      acc_q <= {acc_q[55:0], rdata_q};
    end
    if (in_fire && room && count_q == CW'(1)) begin
      fn_q <= in_byte_i;
    end
    if (in_fire && room && count_q == CW'(2)) begin
      bc_q <= in_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      crc_q   <= CRC_INIT;
      dly_q   <= '0;
      take_q  <= 1'b0;
    end else begin
      take_q <= cmd_i.rd_en;
      if (cmd_i.clear_frame) begin
        count_q <= '0;
        crc_q   <= CRC_INIT;
        dly_q   <= '0;
      end else if (in_fire) begin
        if (room) begin
          count_q <= count_q + CW'(1);
          if (count_q >= CW'(2)) begin
            crc_q <= crc_feed(crc_q, dly_q[15:8]);
          end
          dly_q <= {dly_q[7:0], in_byte_i};
        end else begin
          count_q <= CW'(FRAME_BYTES + 1);
        end
      end
    end
  end

  // Frame checks, in order of precedence.
  always_comb begin
    chk_reject = 1'b1;
    chk_code   = STATUS_LENGTH;
    priority if (count_q > CW'(FRAME_BYTES) || count_q < CW'(MIN_FRAME)) begin
      chk_code = STATUS_LENGTH;
    end else if (crc_rx != crc_q) begin
      chk_code = STATUS_CRC;
    end else if (fn_q != FUNC_READ_HOLDING || (bc_q != BC_ELEC && bc_q != BC_ENERGY)) begin
      chk_code = STATUS_FORMAT;
    end else if (count_q != CW'(bc_q) + CW'(FRAME_OVERHEAD)) begin
      chk_code = STATUS_LENGTH;
    end else begin
      chk_reject = 1'b0;
      chk_code   = STATUS_VALUE;
    end
  end

  assign stat_o.reject    = chk_reject;
  assign stat_o.code      = chk_code;
  assign stat_o.elec      = (bc_q == BC_ELEC);
  // The sequencer only looks at this while it is taking bytes.
  assign stat_o.frame_end = in_valid_i & in_end_i;
  assign stat_o.out_taken = out_valid_q & out_ready_i;

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_value || cmd_i.load_status) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_value) begin
      out_status_q <= STATUS_VALUE;
      out_idx_q    <= cmd_i.idx;
      out_value_q  <= decode(field_kind(cmd_i.idx), acc_q);
      out_last_q   <= cmd_i.last;
    end else if (cmd_i.load_status) begin
      out_status_q <= chk_code;
      out_idx_q    <= '0;
      out_value_q  <= '0;
      out_last_q   <= 1'b1;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_idx_o    = out_idx_q;
  assign out_value_o  = out_value_q;
  assign out_last_o   = out_last_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(FRAME_BYTES + 1))
    else $error("byte counter beyond saturation value");

  a_no_load_over_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.load_value || cmd_i.load_status) |-> !out_valid_q)
    else $error("output register loaded while a result is pending");

  a_no_input_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.in_ready |-> !out_valid_q && !cmd_i.rd_en)
    else $error("bytes accepted while results are being produced");

  a_clear_restores: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clear_frame |=> count_q == '0 && crc_q == CRC_INIT && dly_q == '0)
    else $error("frame state not restored after frame end");
`endif

endmodule
`default_nettype wire

### sv/modbus_meter_response_decoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// modbus_meter_response_decoder: Modbus RTU meter response decoder
// Checks a read-holding-registers response and emits the meter's fields.
// ----------------------------------------------------------------------------
// Usage: the slave-side stream carries one received byte per request, with
// tlast on the final byte of a frame. While collecting, a byte is taken every
// cycle. After the final byte the block stops taking bytes, checks length,
// CRC, function code and byte count, then emits either one status request
// (tuser nonzero, tlast set) or a run of decoded values: 29 for the electrical
// layout, 5 for the energy layout, tlast on the final one.
// Each value is fetched from the frame store one byte per cycle over its
// single read port, passes a drain and a load step into the output register
// and waits there for tready; the next field is fetched only once it has been
// taken. A stalled receiver simply holds the pending value in the output
// register; nothing is lost. The next frame's bytes are taken once the final
// result has been delivered. Reset clears the byte counter and the CRC state;
// the frame store needs no clearing.
// ----------------------------------------------------------------------------
module modbus_meter_response_decoder
  import mmrd_pkg::*;
#(
  parameter int unsigned FRAME_BYTES = 256
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Input byte stream.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  wire logic        s_axis_tlast,   // frame_end
  // Result stream.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [71:0]      m_axis_tdata,   // [5:0] value_index, [69:6] value, zero above
  output logic [1:0]       m_axis_tuser,   // [1:0] status
  output logic             m_axis_tlast    // last
);

  cmd_t             cmd;
  stat_t            stat;
  status_e          out_status;
  logic [IDX_W-1:0] out_idx;
  logic [63:0]      out_value;

  // The sequencer decides when bytes are taken and which field is fetched.
  mmrd_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  // Storage, CRC, checks, field assembly and the output register.
  mmrd_datapath #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .in_valid_i   (s_axis_tvalid),
    .in_byte_i    (s_axis_tdata),
    .in_end_i     (s_axis_tlast),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_status_o (out_status),
    .out_idx_o    (out_idx),
    .out_value_o  (out_value),
    .out_last_o   (m_axis_tlast)
  );

  assign s_axis_tready = cmd.in_ready;
  assign m_axis_tdata  = {2'b00, out_value, out_idx};
  assign m_axis_tuser  = out_status;

endmodule
`default_nettype wire

### sim/modbus_meter_response_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modbus_meter_response_decoder_tb: self-checking bench of the meter decoder
// Streams Modbus RTU response frames into the decoder: short and broken
// frames, well-formed electrical and energy frames with sentinel and
// boundary field contents, an oversized frame and random traffic. A
// byte-level predictor of the decoder builds the expected result of every
// frame, and each result taken from the output stream is compared field by
// field with the oldest expected one. Both stream sides idle at random; the
// receiver also holds off for a long stretch so that the decoder stalls its
// input.
// ----------------------------------------------------------------------------
module modbus_meter_response_decoder_tb
  import mmrd_pkg::*;
();

  localparam int unsigned FRAME_BYTES  = 256;
  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam int unsigned DRAIN_CYCLES = 300;
  localparam int unsigned STALL_CYCLES = 700;
  localparam int unsigned RANDOM_BYTES = 40;

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;  // [7:0] rx_byte
  logic        s_axis_tlast  = 1'b0;   // frame_end
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;           // [5:0] value_index, [69:6] value, zero above
  logic [1:0]  m_axis_tuser;           // [1:0] status
  logic        m_axis_tlast;           // last

  modbus_meter_response_decoder #(
    .FRAME_BYTES(FRAME_BYTES)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  typedef struct {
    status_e     status;
    logic [5:0]  idx;
    logic [63:0] value;
    logic        last;
  } meter_result_t;

  meter_result_t pending_results[$];
  logic [7:0]    frame_q[$];

  // Predictor copy of the decoder state.
  logic [7:0]  seen_bytes[FRAME_BYTES];
  int unsigned seen_len  = 0;
  logic [15:0] crc_acc   = CRC_INIT;
  logic [15:0] crc_hold  = 16'h0000;

  int unsigned requests_sent = 0;
  int unsigned mismatches    = 0;
  int unsigned cycle_count   = 0;
  int unsigned hold_off      = 0;
  bit          calm          = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // Where each value sits in the frame, how wide it is and whether it is signed.
  function automatic void field_layout(input int idx, output int off, output int nbytes,
                                       output bit sgn);
    if (idx < 12) begin
      off = 3 + 4 * idx; nbytes = 4; sgn = 1'b0;
    end else if (idx < 24) begin
      off = 55 + 4 * (idx - 12); nbytes = 4; sgn = 1'b1;
    end else if (idx == 24) begin
      off = 103; nbytes = 2; sgn = 1'b0;
    end else if (idx < 29) begin
      off = 131 + 2 * (idx - 25); nbytes = 2; sgn = 1'b1;
    end else begin
      off = (idx < 33) ? 3 + 24 * (idx - 29) : 107; nbytes = 8; sgn = 1'b0;
    end
  endfunction

  function automatic logic [63:0] decode_field(input int idx);
    int          off;
    int          nb;
    bit          sgn;
    logic [63:0] v;
    field_layout(idx, off, nb, sgn);
    v = '0;
    for (int i = 0; i < nb; i++) begin
      v = {v[55:0], seen_bytes[off + i]};
    end
    // Sentinels read as zero: all ones unsigned, 7F followed by FF signed.
    if (nb == 2) begin
      if (sgn) begin
        if (v == 64'h7FFF) return '0;
        return {{48{v[15]}}, v[15:0]};
      end
      if (v == 64'hFFFF) return '0;
    end else if (nb == 4) begin
      if (sgn) begin
        if (v == 64'h7FFF_FFFF) return '0;
        return {{32{v[31]}}, v[31:0]};
      end
      if (v == 64'hFFFF_FFFF) return '0;
    end else if (v == '1) begin
      return '0;
    end
    return v;
  endfunction

  // Takes one accepted byte; at frame end queues the results it must cause.
  task automatic meter_model_byte(input logic [7:0] b, input logic fin);
    meter_result_t r;
    logic [15:0]   crc_rx;
    status_e       st;
    bit            good;
    int            first;
    int            count;
    if (seen_len < FRAME_BYTES) begin
      seen_bytes[seen_len] = b;
      seen_len++;
      // The two newest bytes are held back: they may be the CRC itself.
      if (seen_len > 2) crc_acc = crc16_byte(crc_acc, crc_hold[15:8]);
      crc_hold = {crc_hold[7:0], b};
    end else begin
      seen_len = FRAME_BYTES + 1;
    end
    if (fin) begin
      crc_rx = {crc_hold[7:0], crc_hold[15:8]};
      good   = 1'b0;
      st     = STATUS_VALUE;
      if (seen_len > FRAME_BYTES || seen_len < MIN_FRAME) begin
        st = STATUS_LENGTH;
      end else if (crc_rx != crc_acc) begin
        st = STATUS_CRC;
      end else if (seen_bytes[1] != FUNC_READ_HOLDING ||
                   (seen_bytes[2] != BC_ELEC && seen_bytes[2] != BC_ENERGY)) begin
        st = STATUS_FORMAT;
      end else if (seen_len != seen_bytes[2] + FRAME_OVERHEAD) begin
        st = STATUS_LENGTH;
      end else begin
        good = 1'b1;
      end
      if (!good) begin
        r.status = st;
        r.idx    = '0;
        r.value  = '0;
        r.last   = 1'b1;
        pending_results.push_back(r);
      end else begin
        first = (seen_bytes[2] == BC_ELEC) ? 0 : 29;
        count = (seen_bytes[2] == BC_ELEC) ? 29 : 5;
        for (int k = 0; k < count; k++) begin
          r.status = STATUS_VALUE;
          r.idx    = 6'(first + k);
          r.value  = decode_field(first + k);
          r.last   = (k == count - 1);
          pending_results.push_back(r);
        end
      end
      seen_len = 0;
      crc_acc  = CRC_INIT;
      crc_hold = 16'h0000;
    end
  endtask

  // Offers one byte, possibly after a short gap, and waits until it is taken.
  task automatic send_request(input logic [7:0] b, input logic fin);
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= fin;
    do @(posedge clk_i); while (!s_axis_tready);
    meter_model_byte(b, fin);
    requests_sent++;
  endtask

  task automatic begin_frame(input logic [7:0] addr, input logic [7:0] func,
                             input logic [7:0] bc, input int body_len);
    frame_q = {};
    frame_q.push_back(addr);
    frame_q.push_back(func);
    frame_q.push_back(bc);
    repeat (body_len) frame_q.push_back(8'($urandom));
  endtask

  // Overwrites the value fields with boundary patterns; a negative pattern
  // picks one at random per field, some fields keeping their random bytes.
  task automatic plant_fields(input bit elec, input int pattern);
    int first;
    int count;
    int off;
    int nb;
    int p;
    bit sgn;
    first = elec ? 0 : 29;
    count = elec ? 29 : 5;
    for (int k = 0; k < count; k++) begin
      field_layout(first + k, off, nb, sgn);
      p = (pattern < 0) ? int'($urandom_range(0, 8)) : (pattern + k) % 6;
      for (int i = 0; i < nb; i++) begin
        case (p)
          0: frame_q[off + i] = 8'hFF;
          1: frame_q[off + i] = (i == 0) ? 8'h7F : 8'hFF;
          2: frame_q[off + i] = (i == 0) ? 8'h80 : 8'h00;
          3: frame_q[off + i] = 8'h00;
          4: if (i == 0) frame_q[off + i] = frame_q[off + i] | 8'h80;
          5: frame_q[off + i] = (i == nb - 1) ? 8'hFE : 8'hFF;
          default: ;
        endcase
      end
    end
  endtask

  // Appends the CRC, low byte first; a corrupt one differs in at least one bit.
  task automatic seal_frame(input bit corrupt);
    logic [15:0] c;
    c = CRC_INIT;
    foreach (frame_q[i]) c = crc16_byte(c, frame_q[i]);
    if (corrupt) c = c ^ 16'($urandom_range(1, 65535));
    frame_q.push_back(c[7:0]);
    frame_q.push_back(c[15:8]);
  endtask

  task automatic send_frame();
    foreach (frame_q[i]) send_request(frame_q[i], i == frame_q.size() - 1);
  endtask

  task automatic send_layout_frame(input bit elec, input int pattern, input bit corrupt);
    logic [7:0] bc;
    bc = elec ? BC_ELEC : BC_ENERGY;
    begin_frame(8'($urandom), FUNC_READ_HOLDING, bc, int'(bc));
    plant_fields(elec, pattern);
    seal_frame(corrupt);
    send_frame();
  endtask

  // Result checker: every accepted result against the oldest expectation.
  always @(posedge clk_i) begin : check_results
    meter_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result status %0d index %0d value %h", $time,
                 m_axis_tuser, m_axis_tdata[5:0], m_axis_tdata[69:6]);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tuser !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, m_axis_tuser);
          mismatches++;
        end
        if (m_axis_tdata[5:0] !== want.idx) begin
          $display("%0t: value_index expected %0d actual %0d", $time, want.idx,
                   m_axis_tdata[5:0]);
          mismatches++;
        end
        if (m_axis_tdata[69:6] !== want.value) begin
          $display("%0t: value (index %0d) expected %h actual %h", $time, want.idx,
                   want.value, m_axis_tdata[69:6]);
          mismatches++;
        end
        if (m_axis_tlast !== want.last) begin
          $display("%0t: last (index %0d) expected %b actual %b", $time, want.idx,
                   want.last, m_axis_tlast);
          mismatches++;
        end
      end
    end
  end

  // Receiver: random short stalls, one long hold-off on request, none at the end.
  initial begin
    forever begin
      if (hold_off != 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold_off) @(posedge clk_i);
        hold_off = 0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // Frames too short to hold a header, and five-byte frames that get past
  // the length floor to reach the CRC, format and length-match checks.
  task automatic test_short_frames();
    frame_q = {8'hFF};
    send_frame();
    frame_q = {8'h00, FUNC_READ_HOLDING, BC_ELEC, 8'h00};
    send_frame();
    begin_frame(8'h00, FUNC_READ_HOLDING, BC_ELEC, 0);
    seal_frame(1'b0);
    send_frame();
    begin_frame(8'hFF, 8'h04, BC_ELEC, 0);
    seal_frame(1'b0);
    send_frame();
    begin_frame(8'h11, FUNC_READ_HOLDING, 8'h71, 0);
    seal_frame(1'b0);
    send_frame();
    // A received CRC of all ones is just a wrong CRC here.
    frame_q = {8'h01, FUNC_READ_HOLDING, BC_ENERGY, 8'hFF, 8'hFF};
    send_frame();
  endtask

  // Every field gets a sentinel, a boundary pattern or random bytes.
  task automatic test_electrical_layout();
    send_layout_frame(1'b1, -1, 1'b0);
  endtask

  // The five fields carry five different boundary patterns.
  task automatic test_energy_layout();
    send_layout_frame(1'b0, 0, 1'b0);
  endtask

  // One byte more than the store holds: the excess byte is dropped.
  task automatic test_oversized_frames();
    begin_frame(8'($urandom), FUNC_READ_HOLDING, BC_ELEC, FRAME_BYTES - 4);
    seal_frame(1'b0);
    send_frame();
  endtask

  // The receiver stops long enough that the next frame backs up at the input.
  task automatic test_stalled_receiver();
    hold_off = STALL_CYCLES;
    begin_frame(8'h5A, FUNC_READ_HOLDING, BC_ENERGY, 0);
    seal_frame(1'b1);
    send_frame();
    frame_q = {8'h5A, FUNC_READ_HOLDING};
    send_frame();
  endtask

  task automatic random_frame();
    int         pick;
    logic [7:0] func;
    logic [7:0] bc;
    pick = $urandom_range(0, 99);
    bc   = $urandom_range(0, 1) ? BC_ELEC : BC_ENERGY;
    if (pick < 25) begin
      // Unknown function or byte count, with a CRC that holds.
      func = $urandom_range(0, 1) ? FUNC_READ_HOLDING : 8'($urandom);
      begin_frame(8'($urandom), func, 8'($urandom), int'($urandom_range(0, 30)));
      seal_frame(1'b0);
      send_frame();
    end else if (pick < 50) begin
      // Good header and CRC, but the length disagrees with the byte count.
      begin_frame(8'($urandom), FUNC_READ_HOLDING, bc, int'($urandom_range(0, 40)));
      seal_frame(1'b0);
      send_frame();
    end else if (pick < 75) begin
      frame_q = {};
      repeat ($urandom_range(1, 12)) frame_q.push_back(8'($urandom));
      send_frame();
    end else begin
      frame_q = {};
      repeat ($urandom_range(3, 20)) frame_q.push_back(8'($urandom));
      seal_frame(1'($urandom_range(0, 1)));
      send_frame();
    end
  endtask

  task automatic test_random_frames();
    int unsigned req_start;
    req_start = requests_sent;
    while (requests_sent - req_start < RANDOM_BYTES) begin
      random_frame();
    end
  endtask

  // Back-to-back traffic with both sides always ready.
  task automatic test_calm_tail();
    calm = 1'b1;
    random_frame();
    random_frame();
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_short_frames();
    test_electrical_layout();
    test_energy_layout();
    test_oversized_frames();
    test_stalled_receiver();
    test_random_frames();
    test_calm_tail();
    s_axis_tvalid <= 1'b0;
    s_axis_tlast  <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
